@@ rtl/core/obd_pkg.sv @@
// ----------------------------------------------------------------------------
// obd_pkg
// Shared types and constants for the OBD-II mode 1 sensor record decoder:
// request and result payloads, the kept record and the status and PID codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obd_pkg;

    // response mode and frame length limits
    localparam logic [7:0] MODE1_RESPONSE = 8'h41;
    localparam logic [3:0] MIN_FRAME_LEN  = 4'd3;
    localparam logic [3:0] WORD_FRAME_LEN = 4'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_BAD_MODE = 2'd2;

    // parameter identifiers handled
    localparam logic [7:0] PID_LOAD       = 8'h04;
    localparam logic [7:0] PID_COOLANT    = 8'h05;
    localparam logic [7:0] PID_SHORT_TRIM = 8'h06;
    localparam logic [7:0] PID_LONG_TRIM  = 8'h07;
    localparam logic [7:0] PID_RPM        = 8'h0C;
    localparam logic [7:0] PID_SPEED      = 8'h0D;
    localparam logic [7:0] PID_MAF        = 8'h10;
    localparam logic [7:0] PID_THROTTLE   = 8'h11;

    // valid mask bits
    localparam logic [7:0] VF_RPM        = 8'h01;
    localparam logic [7:0] VF_COOLANT    = 8'h02;
    localparam logic [7:0] VF_SPEED      = 8'h04;
    localparam logic [7:0] VF_LOAD       = 8'h08;
    localparam logic [7:0] VF_MAF        = 8'h10;
    localparam logic [7:0] VF_THROTTLE   = 8'h20;
    localparam logic [7:0] VF_SHORT_TRIM = 8'h40;
    localparam logic [7:0] VF_LONG_TRIM  = 8'h80;

    // one received response frame
    typedef struct packed {
        logic       start_new;
        logic [3:0] frame_length;
        logic [7:0] mode_byte;
        logic [7:0] pid_byte;
        logic [7:0] data_a;
        logic [7:0] data_b;
    } frame_t;

    // kept sensor record
    typedef struct packed {
        logic [13:0]       engine_rpm;
        logic [7:0]        coolant_raw;
        logic [7:0]        vehicle_speed;
        logic [6:0]        load_percent;
        logic [15:0]       air_flow;
        logic [6:0]        throttle_percent;
        logic signed [7:0] trim_short;
        logic signed [7:0] trim_long;
        logic [7:0]        valid_flags;
    } record_t;

    // one result: status and the whole record
    typedef struct packed {
        logic [1:0]        status;
        logic [13:0]       engine_rpm;
        logic [7:0]        coolant_raw;
        logic [7:0]        vehicle_speed;
        logic [6:0]        load_percent;
        logic [15:0]       air_flow;
        logic [6:0]        throttle_percent;
        logic signed [7:0] trim_short;
        logic signed [7:0] trim_long;
        logic [7:0]        valid_flags;
    } result_t;

endpackage

@@ rtl/core/obd_pid_sensor_record_decoder.sv @@
// ----------------------------------------------------------------------------
// obd_pid_sensor_record_decoder
// Takes one OBD-II response frame per request and returns one result per
// request: a status (ok, frame too short, not a mode 1 response) and the whole
// kept sensor record after that frame. Known PIDs update their field and set
// their bit in valid_flags, RPM and MAF only if frame_length is 4 or more;
// start_new clears the record first, even for a rejected frame. A request
// passes an input register and then a result register; one request is
// taken every cycle while the result side is not stalled, and the record
// register is updated in the same cycle that a result is loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obd_pid_sensor_record_decoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    output logic             frame_stall,
    input  obd_pkg::frame_t  frame,
    output logic             result_valid,
    input  logic             result_stall,
    output obd_pkg::result_t result
);

    logic              frame_valid_reg;
    logic              frame_valid_next;
    obd_pkg::frame_t   frame_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    obd_pkg::result_t  result_reg;
    obd_pkg::record_t  record_cur;
    obd_pkg::record_t  record_new;
    logic [1:0]        status_new;
    logic              advance;
    logic              accept;

    // handshake control
    assign advance     = frame_valid_reg && (!result_valid_reg || !result_stall);
    assign frame_stall = frame_valid_reg && !advance;
    assign accept      = frame_valid && !frame_stall;

    assign frame_valid_next  = accept || (frame_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            frame_valid_reg  <= frame_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg <= frame;
        end
    end

    obd_decode u_decode (
        .frame      (frame_reg),
        .record_cur (record_cur),
        .record_new (record_new),
        .status     (status_new)
    );

    obd_record u_record (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .record_next (record_new),
        .record_cur  (record_cur)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= {status_new, record_new};
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // a stall on the request side only comes from a full input register
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> frame_valid_reg)
        else $error("request stalled with empty input register");

    // a full input register behind a stalled result must stall requests
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid_reg && result_valid_reg && result_stall) |-> frame_stall)
        else $error("request taken while result side is stalled");

    // the shown result carries the record as it is now kept
    a_result_matches_record: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> ((result_reg.valid_flags == record_cur.valid_flags)
                              && (result_reg.air_flow == record_cur.air_flow)
                              && (result_reg.engine_rpm == record_cur.engine_rpm)))
        else $error("result record differs from kept record");

    // a rejected frame without a clear leaves the record alone
    a_reject_keeps_record: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (status_new != obd_pkg::ST_OK) && !frame_reg.start_new)
        |=> $stable(record_cur))
        else $error("rejected frame changed the record");

    // a clear leaves only the bit of the decoded quantity, if any
    a_clear_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && frame_reg.start_new) |=> $onehot0(record_cur.valid_flags))
        else $error("clear left stale valid bits");
`endif

endmodule

@@ rtl/core/obd_decode.sv @@
// ----------------------------------------------------------------------------
// obd_decode
// Combinational frame check and PID decode: takes the registered frame and
// the current record, gives the status and the record after this frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obd_decode (
    input  obd_pkg::frame_t  frame,
    input  obd_pkg::record_t record_cur,
    output obd_pkg::record_t record_new,
    output logic [1:0]       status
);

    // a * 100 / 255, divide by 255 as add of the high byte and shift
    function automatic logic [6:0] pct_of_byte(input logic [7:0] a);
        logic [14:0] x;
        logic [15:0] s;
        begin
            x = 15'(a) * 15'd100;
            s = 16'(x) + 16'(x >> 8) + 16'd1;
            return s[14:8];
        end
    endfunction

    // (a - 128) * 100 / 128 truncated toward zero, two's complement
    function automatic logic [7:0] trim_of_byte(input logic [7:0] a);
        logic [7:0]  mag;
        logic [13:0] m;
        logic [6:0]  q;
        begin
            mag = a[7] ? {1'b0, a[6:0]} : (8'd128 - a);
            m   = 14'(mag) * 14'd100;
            q   = m[13:7];
            return a[7] ? {1'b0, q} : (8'd0 - {1'b0, q});
        end
    endfunction

    logic        word_ok;
    logic [15:0] word;

    assign word_ok = (frame.frame_length >= obd_pkg::WORD_FRAME_LEN);
    assign word    = {frame.data_a, frame.data_b};

    // check the frame and update the selected field
    always_comb
    begin
        record_new = frame.start_new ? '0 : record_cur;
        status     = obd_pkg::ST_OK;
        if (frame.frame_length < obd_pkg::MIN_FRAME_LEN)
        begin
            status = obd_pkg::ST_SHORT;
        end
        else if (frame.mode_byte != obd_pkg::MODE1_RESPONSE)
        begin
            status = obd_pkg::ST_BAD_MODE;
        end
        else
        begin
            unique case (frame.pid_byte)
                obd_pkg::PID_LOAD:
                begin
                    record_new.load_percent = pct_of_byte(frame.data_a);
                    record_new.valid_flags  = record_new.valid_flags | obd_pkg::VF_LOAD;
                end
                obd_pkg::PID_COOLANT:
                begin
                    record_new.coolant_raw = frame.data_a;
                    record_new.valid_flags = record_new.valid_flags | obd_pkg::VF_COOLANT;
                end
                obd_pkg::PID_SHORT_TRIM:
                begin
                    record_new.trim_short  = trim_of_byte(frame.data_a);
                    record_new.valid_flags = record_new.valid_flags
                                             | obd_pkg::VF_SHORT_TRIM;
                end
                obd_pkg::PID_LONG_TRIM:
                begin
                    record_new.trim_long   = trim_of_byte(frame.data_a);
                    record_new.valid_flags = record_new.valid_flags
                                             | obd_pkg::VF_LONG_TRIM;
                end
                obd_pkg::PID_RPM:
                begin
                    if (word_ok)
                    begin
                        record_new.engine_rpm  = word[15:2];
                        record_new.valid_flags = record_new.valid_flags | obd_pkg::VF_RPM;
                    end
                end
                obd_pkg::PID_SPEED:
                begin
                    record_new.vehicle_speed = frame.data_a;
                    record_new.valid_flags   = record_new.valid_flags | obd_pkg::VF_SPEED;
                end
                obd_pkg::PID_MAF:
                begin
                    if (word_ok)
                    begin
                        record_new.air_flow    = word;
                        record_new.valid_flags = record_new.valid_flags | obd_pkg::VF_MAF;
                    end
                end
                obd_pkg::PID_THROTTLE:
                begin
                    record_new.throttle_percent = pct_of_byte(frame.data_a);
                    record_new.valid_flags      = record_new.valid_flags
                                                  | obd_pkg::VF_THROTTLE;
                end
                default:
                begin
                    record_new.valid_flags = record_new.valid_flags;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/obd_record.sv @@
// ----------------------------------------------------------------------------
// obd_record
// Kept sensor record: cleared by reset, loaded with the decoded record each
// time a request moves on to the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obd_record (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  obd_pkg::record_t record_next,
    output obd_pkg::record_t record_cur
);

    obd_pkg::record_t record_reg;

    // record update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_reg <= '0;
        end
        else if (load)
        begin
            record_reg <= record_next;
        end
    end

    assign record_cur = record_reg;

endmodule
